>>> hw/rtl/ukrt_pkg.sv
// Package for the keyed record table: sizes, request kinds, status codes, states, beat, record and cell control types.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package ukrt_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request kinds
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_COUNT  = 2'd3
    } kind_e;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_DUP     = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    // Request beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [63:0] model_text_low;
        logic [7:0]  model_text_high;
        logic [15:0] tank_volume;
        logic [15:0] engine_size;
        logic [7:0]  seat_count;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found_model_low;
        logic [7:0]  found_model_high;
        logic [15:0] found_tank;
        logic [15:0] found_engine;
        logic [7:0]  found_seats;
        logic [4:0]  entries;
    } rsp_t;

    // One stored record
    typedef struct packed {
        logic [31:0] key;
        logic [63:0] model_low;
        logic [7:0]  model_high;
        logic [15:0] tank;
        logic [15:0] engine;
        logic [7:0]  seats;
    } rec_t;

    // Per-cell update controls
    typedef struct packed {
        logic load;
        logic shift_en;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/ukrt_cell.sv
// One table cell: holds a record, compares its key, shifts down from its neighbor.
// Depends on ukrt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ukrt_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               occupied,
    input  wire logic [31:0]        req_key,
    input  wire ukrt_pkg::rec_t     new_rec,
    input  wire ukrt_pkg::rec_t     next_rec,
    input  wire ukrt_pkg::cell_ctl_t ctl,
    input  wire logic               seen_in,
    output logic                    seen_out,
    output logic                    hit,
    output ukrt_pkg::rec_t          rec
);

    ukrt_pkg::rec_t rec_reg;
    logic           hit_reg;

    // Key compare, registered for the execute cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= occupied && (rec_reg.key == req_key);
        end
    end

    // Record storage: append load or shift down from the upper neighbor
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rec_reg <= new_rec;
        end
        else if (ctl.shift_en && seen_out)
        begin
            rec_reg <= next_rec;
        end
    end

    // Prefix of hits: this cell and all above the deleted one move
    assign seen_out = seen_in | hit_reg;
    assign hit      = hit_reg;
    assign rec      = rec_reg;

endmodule
`default_nettype wire

>>> hw/rtl/unique_key_record_table.sv
// Top level of the keyed record table: controller, entry count and the cell chain.
// Depends on ukrt_pkg and ukrt_cell.
// Flow: an accepted request passes through the compare and execute states, and done
//   is registered from the execute state; busy is high for one cycle (the compare cycle)
//   per beat, set by the registered key compare, so a new request can be taken in execute.
// Reset clears the entry count and the controller; record storage is not cleared.
// The result is flagged by done for exactly one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module unique_key_record_table (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire ukrt_pkg::req_t request,
    output logic                busy,
    output logic                done,
    output ukrt_pkg::rsp_t      result
);

    localparam int N = ukrt_pkg::CAPACITY;
    localparam int W = ukrt_pkg::CNT_W;

    ukrt_pkg::state_t state_reg, state_next;
    ukrt_pkg::req_t   req_reg;
    logic [W-1:0]     count_reg, count_next;
    ukrt_pkg::rsp_t   result_reg, result_next;
    logic             done_reg, done_next;

    ukrt_pkg::rec_t      new_rec;
    ukrt_pkg::rec_t      cell_rec [N];
    ukrt_pkg::cell_ctl_t cell_ctl [N];
    logic [N-1:0]        hit;
    logic [N-1:0]        seen;
    logic [N-1:0]        occ;

    logic           accept;
    logic           exec;
    logic           any_hit;
    logic           full;
    logic           empty;
    logic           insert_ok;
    logic           delete_ok;
    logic           lookup_ok;
    ukrt_pkg::rec_t found;

    // Busy only in the compare cycle
    assign busy   = (state_reg == ukrt_pkg::S_CMP);
    assign accept = start && !busy;
    assign exec   = (state_reg == ukrt_pkg::S_EXEC);

    // Record built from the held request
    assign new_rec.key        = req_reg.key;
    assign new_rec.model_low  = req_reg.model_text_low;
    assign new_rec.model_high = req_reg.model_text_high;
    assign new_rec.tank       = req_reg.tank_volume;
    assign new_rec.engine     = req_reg.engine_size;
    assign new_rec.seats      = req_reg.seat_count;

    // Cell chain
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        ukrt_pkg::rec_t nbr;
        logic           sin;

        if (g == N - 1)
        begin : g_last
            assign nbr = cell_rec[g];
        end
        else
        begin : g_mid
            assign nbr = cell_rec[g + 1];
        end

        if (g == 0)
        begin : g_first
            assign sin = 1'b0;
        end
        else
        begin : g_rest
            assign sin = seen[g - 1];
        end

        assign occ[g]               = (count_reg > W'(g));
        assign cell_ctl[g].load     = insert_ok && (count_reg == W'(g));
        assign cell_ctl[g].shift_en = delete_ok;

        ukrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .occupied (occ[g]),
            .req_key  (req_reg.key),
            .new_rec  (new_rec),
            .next_rec (nbr),
            .ctl      (cell_ctl[g]),
            .seen_in  (sin),
            .seen_out (seen[g]),
            .hit      (hit[g]),
            .rec      (cell_rec[g])
        );
    end

    // Execute decisions
    assign any_hit   = |hit;
    assign full      = (count_reg == W'(N));
    assign empty     = (count_reg == '0);
    assign insert_ok = exec && (req_reg.kind == ukrt_pkg::KIND_INSERT) && !full && !any_hit;
    assign delete_ok = exec && (req_reg.kind == ukrt_pkg::KIND_DELETE) && !empty && any_hit;
    assign lookup_ok = (req_reg.kind == ukrt_pkg::KIND_LOOKUP) && !empty && any_hit;

    // Matching record (keys are unique, at most one hit)
    always_comb
    begin
        found = '0;
        for (int i = 0; i < N; i++)
        begin
            if (hit[i])
            begin
                found = found | cell_rec[i];
            end
        end
    end

    // Controller, count update and result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        case (state_reg)
            ukrt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = ukrt_pkg::S_CMP;
                end
            end
            ukrt_pkg::S_CMP:
            begin
                state_next = ukrt_pkg::S_EXEC;
            end
            ukrt_pkg::S_EXEC:
            begin
                state_next = accept ? ukrt_pkg::S_CMP : ukrt_pkg::S_IDLE;
                done_next  = 1'b1;

                if (insert_ok)
                begin
                    count_next = count_reg + W'(1);
                end
                else if (delete_ok)
                begin
                    count_next = count_reg - W'(1);
                end

                result_next = '0;
                case (req_reg.kind)
                    ukrt_pkg::KIND_INSERT:
                    begin
                        if (full)
                        begin
                            result_next.status = ukrt_pkg::ST_FULL;
                        end
                        else if (any_hit)
                        begin
                            result_next.status = ukrt_pkg::ST_DUP;
                        end
                        else
                        begin
                            result_next.status = ukrt_pkg::ST_OK;
                        end
                    end
                    ukrt_pkg::KIND_LOOKUP, ukrt_pkg::KIND_DELETE:
                    begin
                        if (empty)
                        begin
                            result_next.status = ukrt_pkg::ST_EMPTY;
                        end
                        else if (!any_hit)
                        begin
                            result_next.status = ukrt_pkg::ST_MISSING;
                        end
                        else
                        begin
                            result_next.status = ukrt_pkg::ST_OK;
                        end
                    end
                    default:
                    begin
                        result_next.status = ukrt_pkg::ST_OK;
                    end
                endcase

                if (lookup_ok)
                begin
                    result_next.found_model_low  = found.model_low;
                    result_next.found_model_high = found.model_high;
                    result_next.found_tank       = found.tank;
                    result_next.found_engine     = found.engine;
                    result_next.found_seats      = found.seats;
                end
                result_next.entries = 5'(count_next);
            end
            default:
            begin
                state_next = ukrt_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ukrt_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

>>> bench/unique_key_record_table_tb.sv
// Self-checking bench for unique_key_record_table: insert, lookup, delete and count beats,
// checked against an in-bench record table predictor. Depends on ukrt_pkg and the RTL.
`timescale 1ns / 1ps
module unique_key_record_table_tb;
    import ukrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CHUNKS         = 10;
    localparam int CHUNK_ITEMS    = 55;
    localparam int KEY_POOL       = 48;

    typedef enum int {
        PL_ZERO,
        PL_ONES,
        PL_RANDOM
    } fill_e;

    typedef struct {
        req_t        req;
        int unsigned gap_pct;
    } pending_t;

    logic clk     = 1'b0;
    logic rst_n   = 1'b0;
    logic start   = 1'b0;
    req_t request = '0;
    logic busy;
    logic done;
    rsp_t result;

    pending_t    req_pending_q[$];
    rsp_t        rsp_expected_q[$];
    rec_t        rec_table[CAPACITY];
    int unsigned rec_count = 0;
    logic [31:0] stim_keys[$];
    logic        beat_taken = 1'b0;
    int unsigned errors = 0;
    int unsigned beats_in = 0;
    int unsigned beats_out = 0;
    int unsigned idle_cycles = 0;
    int unsigned full_hits = 0;
    int unsigned status_seen[5] = '{0, 0, 0, 0, 0};

    unique_key_record_table dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    // Position of a key among the valid records, -1 if absent
    function automatic int find_rec(logic [31:0] k);
        for (int i = 0; i < rec_count; i++)
        begin
            if (rec_table[i].key == k)
                return i;
        end
        return -1;
    endfunction

    // Apply one request to the table image and return the status beat it should produce
    function automatic rsp_t table_apply(req_t rq);
        rsp_t r;
        rec_t rec;
        int   pos;
        r = '0;
        r.status = ST_OK;
        pos = find_rec(rq.key);
        case (kind_e'(rq.kind))
            KIND_INSERT:
            begin
                // full check wins over duplicate check
                if (rec_count >= CAPACITY)
                    r.status = ST_FULL;
                else if (pos >= 0)
                    r.status = ST_DUP;
                else
                begin
                    rec.key        = rq.key;
                    rec.model_low  = rq.model_text_low;
                    rec.model_high = rq.model_text_high;
                    rec.tank       = rq.tank_volume;
                    rec.engine     = rq.engine_size;
                    rec.seats      = rq.seat_count;
                    rec_table[rec_count] = rec;
                    rec_count++;
                end
            end
            KIND_LOOKUP:
            begin
                if (rec_count == 0)
                    r.status = ST_EMPTY;
                else if (pos < 0)
                    r.status = ST_MISSING;
                else
                begin
                    r.found_model_low  = rec_table[pos].model_low;
                    r.found_model_high = rec_table[pos].model_high;
                    r.found_tank       = rec_table[pos].tank;
                    r.found_engine     = rec_table[pos].engine;
                    r.found_seats      = rec_table[pos].seats;
                end
            end
            KIND_DELETE:
            begin
                if (rec_count == 0)
                    r.status = ST_EMPTY;
                else if (pos < 0)
                    r.status = ST_MISSING;
                else
                begin
                    // close the hole so valid records stay packed
                    for (int i = pos; i + 1 < rec_count; i++)
                        rec_table[i] = rec_table[i + 1];
                    rec_count--;
                end
            end
            default: ;
        endcase
        r.entries = 5'(rec_count);
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Key choice: if preferred, mostly keys believed present, else a small pool, extremes or any value
    function automatic logic [31:0] pick_key(bit prefer_known);
        if (prefer_known && stim_keys.size() > 0 && $urandom_range(99) < 75)
            return stim_keys[$urandom_range(stim_keys.size() - 1)];
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom;
            default: return $urandom_range(KEY_POOL - 1);
        endcase
    endfunction

    // Build a beat, track which keys the table should hold, and queue it
    task automatic queue_req(kind_e k, logic [31:0] key, fill_e fill, int unsigned gap);
        pending_t p;
        int       hit;
        p.gap_pct = gap;
        p.req.kind = k;
        p.req.key  = key;
        case (fill)
            PL_ZERO:
            begin
                p.req.model_text_low  = '0;
                p.req.model_text_high = '0;
                p.req.tank_volume     = '0;
                p.req.engine_size     = '0;
                p.req.seat_count      = '0;
            end
            PL_ONES:
            begin
                p.req.model_text_low  = '1;
                p.req.model_text_high = '1;
                p.req.tank_volume     = '1;
                p.req.engine_size     = '1;
                p.req.seat_count      = '1;
            end
            default:
            begin
                p.req.model_text_low  = {$urandom, $urandom};
                p.req.model_text_high = 8'($urandom);
                p.req.tank_volume     = 16'($urandom);
                p.req.engine_size     = 16'($urandom);
                p.req.seat_count      = 8'($urandom);
            end
        endcase
        hit = -1;
        for (int i = 0; i < stim_keys.size(); i++)
        begin
            if (stim_keys[i] == key)
                hit = i;
        end
        if (k == KIND_INSERT && hit < 0 && stim_keys.size() < CAPACITY)
            stim_keys.push_back(key);
        else if (k == KIND_DELETE && hit >= 0)
            stim_keys.delete(hit);
        req_pending_q.push_back(p);
    endtask

    // Driver: present the next beat at the falling edge, with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || beat_taken)
        begin
            if (req_pending_q.size() > 0 && $urandom_range(99) >= req_pending_q[0].gap_pct)
            begin
                request <= req_pending_q[0].req;
                start   <= 1'b1;
                req_pending_q.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check results, predict accepted beats, track progress
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            beat_taken  <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            if (done)
            begin
                beats_out++;
                if (result.status < 5)
                    status_seen[result.status]++;
                if (rsp_expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat: expected none, got %p", $time, result);
                end
                else
                begin
                    rsp_t want;
                    want = rsp_expected_q.pop_front();
                    check_field("status", 64'(want.status), 64'(result.status));
                    check_field("found_model_low", want.found_model_low, result.found_model_low);
                    check_field("found_model_high", 64'(want.found_model_high),
                                64'(result.found_model_high));
                    check_field("found_tank", 64'(want.found_tank), 64'(result.found_tank));
                    check_field("found_engine", 64'(want.found_engine),
                                64'(result.found_engine));
                    check_field("found_seats", 64'(want.found_seats), 64'(result.found_seats));
                    check_field("entries", 64'(want.entries), 64'(result.entries));
                end
            end
            if (start && !busy)
            begin
                rsp_expected_q.push_back(table_apply(request));
                beats_in++;
                if (request.kind == KIND_INSERT && rec_count == CAPACITY
                    && rsp_expected_q[$].status == ST_OK)
                    full_hits++;
            end
            beat_taken  <= start && !busy;
            idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog on cycles with no beat moving either way
    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     rsp_expected_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus and end of test
    initial
    begin
        int unsigned gap;
        int unsigned r;
        bit          filling;
        kind_e       k;

        // directed: empty table, extremes, duplicate, full table, deletes at each end
        queue_req(KIND_LOOKUP, 32'h0000_0005, PL_RANDOM, 0);
        queue_req(KIND_DELETE, 32'hFFFF_FFFF, PL_RANDOM, 0);
        queue_req(KIND_COUNT, $urandom, PL_RANDOM, 0);
        queue_req(KIND_INSERT, 32'h0, PL_ZERO, 0);
        queue_req(KIND_INSERT, 32'hFFFF_FFFF, PL_ONES, 0);
        queue_req(KIND_INSERT, 32'h0, PL_RANDOM, 0);
        queue_req(KIND_LOOKUP, 32'hFFFF_FFFF, PL_ZERO, 0);
        queue_req(KIND_LOOKUP, 32'h0, PL_ONES, 0);
        queue_req(KIND_LOOKUP, 32'h1234_5678, PL_RANDOM, 0);
        queue_req(KIND_DELETE, 32'h8000_0000, PL_RANDOM, 0);
        for (int i = 0; i < CAPACITY - 2; i++)
            queue_req(KIND_INSERT, 100 + i, PL_RANDOM, 0);
        queue_req(KIND_INSERT, 32'hFFFF_FFFF, PL_RANDOM, 0);
        queue_req(KIND_INSERT, 32'd777, PL_RANDOM, 0);
        queue_req(KIND_DELETE, 32'h0, PL_RANDOM, 0);
        queue_req(KIND_DELETE, 100 + CAPACITY - 3, PL_RANDOM, 0);
        queue_req(KIND_DELETE, 32'd105, PL_RANDOM, 0);
        queue_req(KIND_COUNT, 32'h0, PL_ZERO, 0);

        // random: chunks alternate fill and drain bias, and cycle through gap settings
        for (int c = 0; c < CHUNKS; c++)
        begin
            case (c % 4)
                1:       gap = 65;
                3:       gap = 37;
                default: gap = 0;
            endcase
            filling = (c % 2 == 0);
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                r = $urandom_range(99);
                if (filling)
                    k = (r < 55) ? KIND_INSERT : (r < 75) ? KIND_LOOKUP :
                        (r < 90) ? KIND_DELETE : KIND_COUNT;
                else
                    k = (r < 15) ? KIND_INSERT : (r < 35) ? KIND_LOOKUP :
                        (r < 85) ? KIND_DELETE : KIND_COUNT;
                r = $urandom_range(19);
                queue_req(k, pick_key(k != KIND_INSERT || $urandom_range(99) < 20),
                          (r == 0) ? PL_ZERO : (r == 1) ? PL_ONES : PL_RANDOM, gap);
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(posedge clk);
        while (req_pending_q.size() != 0 || start || rsp_expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d results; table filled to capacity %0d times.",
                 beats_in, beats_out, full_hits);
        $display("Statuses seen: ok %0d, full %0d, duplicate %0d, missing %0d, empty %0d.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
                 status_seen[ST_MISSING], status_seen[ST_EMPTY]);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
